// ----- hdl/wav_header_checker_core_defines.svh -----
// Assertion macros for the WAV header checker.
`ifndef WAV_HEADER_CHECKER_CORE_DEFINES_SVH
`define WAV_HEADER_CHECKER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define WHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/whc_pkg.sv -----
// ----------------------------------------------------------------------------
// whc_pkg
// Types, constants and tags shared by the WAV header checker.
// ----------------------------------------------------------------------------
package whc_pkg;
    localparam int COUNT_BITS_DEF = 32;
    localparam int DIV_BITS = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_RIFF     = 4'd2;
    localparam logic [3:0] ST_WAVE     = 4'd3;
    localparam logic [3:0] ST_FMT      = 4'd4;
    localparam logic [3:0] ST_TRUNC    = 4'd5;
    localparam logic [3:0] ST_NOT_PCM  = 4'd6;
    localparam logic [3:0] ST_RATE     = 4'd7;
    localparam logic [3:0] ST_ZERO_DIV = 4'd8;

    typedef enum logic [2:0] {
        S_RUN,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_DIV2_START,
        S_DIV2_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_sel;
        logic latch_q1;
        logic fin_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_seen;
    } t_stat;
endpackage

// ----- hdl/whc_stream_if.sv -----
// ----------------------------------------------------------------------------
// whc_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface whc_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wav_header_checker_core.sv -----
// ----------------------------------------------------------------------------
// wav_header_checker_core
// RIFF/WAVE PCM header checker over a byte stream.
// ----------------------------------------------------------------------------
// Input channel: one word per file byte (data_byte, last_byte flag).
// Output channel: one result word per file, given after the last byte.
// Bytes are taken one per cycle while parsing. After the last byte the
// block stops intake, runs the rate check division and the frame count
// division on one shared restoring divider (one quotient bit per cycle),
// then loads the result register, which raises result valid. The next
// file's bytes are taken as soon as the result is loaded, while it still
// waits in the output register. If the receiver stalls with a result
// still held, the next result waits in the sequencer. Reset clears all
// parser state and drops output valid; the block is then ready for the
// first byte of a file.
// Counter width is set by COUNT_BITS; bytes beyond its range are taken
// but neither counted nor parsed.
// ----------------------------------------------------------------------------
`include "wav_header_checker_core_defines.svh"
module wav_header_checker_core #(
    parameter int COUNT_BITS = whc_pkg::COUNT_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    whc_stream_if.sink   in_ch,
    whc_stream_if.source out_ch
);
    import whc_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;

    whc_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    whc_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_byte(in_ch.data.data_byte), .i_last(in_ch.data.last_byte),
        .o_status(out_ch.data.status),
        .o_channel_count(out_ch.data.channel_count),
        .o_sample_rate(out_ch.data.sample_rate),
        .o_sample_bits(out_ch.data.sample_bits),
        .o_payload_bytes(out_ch.data.payload_bytes),
        .o_frame_total(out_ch.data.frame_total),
        .o_payload_offset(out_ch.data.payload_offset),
        .o_file_length(out_ch.data.file_length)
    );

    `WHC_ASSERT_IMP(a_clear_only_in_out, i_clk, i_rst_n, w_cmd.clear, !w_cmd.take)
    `WHC_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, w_cmd.fin_load, out_ch.valid)
    `WHC_ASSERT_IMP(a_no_intake_after_last, i_clk, i_rst_n, w_stat.last_seen, !w_cmd.take)
endmodule

// ----- hdl/whc_divider.sv -----
// ----------------------------------------------------------------------------
// whc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module whc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import whc_pkg::*;
    logic [31:0] r_q, n_q, r_den;
    logic [32:0] r_rem, n_rem, w_tr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        w_tr = {r_rem[31:0], r_q[31]};
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = 6'(DIV_BITS); n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_tr >= {1'b0, r_den}) begin
                n_rem = w_tr - {1'b0, r_den};
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_tr;
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_q;
endmodule

// ----- hdl/whc_datapath.sv -----
// ----------------------------------------------------------------------------
// whc_datapath
// Byte parser, header field capture, final checks and result register.
// ----------------------------------------------------------------------------
module whc_datapath #(
    parameter int COUNT_BITS = whc_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  whc_pkg::t_cmd i_cmd,
    output whc_pkg::t_stat o_stat,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic [3:0]    o_status,
    output logic [15:0]   o_channel_count,
    output logic [31:0]   o_sample_rate,
    output logic [15:0]   o_sample_bits,
    output logic [31:0]   o_payload_bytes,
    output logic [31:0]   o_frame_total,
    output logic [32:0]   o_payload_offset,
    output logic [31:0]   o_file_length
);
    import whc_pkg::*;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0] r_cnt;
    logic [4:0]  r_flags;
    logic [31:0] r_fsize, r_rate, r_avg, r_clen;
    logic [15:0] r_fcode, r_chan, r_align, r_bits;
    logic        r_fact, r_last;
    logic [31:0] r_q1;

    logic [63:0] w_pos, w_p, w_n;
    logic [1:0]  w_lane;
    logic [7:0]  w_tag_data, w_tag_fact;
    logic [4:0]  n_flags;
    logic [31:0] n_fsize, n_rate, n_avg, n_clen;
    logic [15:0] n_fcode, n_chan, n_align, n_bits;
    logic        n_fact;

    function automatic logic [31:0] put32(logic [31:0] f, logic [1:0] l, logic [7:0] b);
        logic [31:0] v;
        v = f;
        v[8*l +: 8] = b;
        return v;
    endfunction

    function automatic logic [7:0] tagb(logic [31:0] t, logic [1:0] l);
        return t[8*l +: 8];
    endfunction

    assign w_pos = 64'(r_cnt);
    assign w_lane = w_pos[1:0];

    always_comb begin
        logic [63:0] p;
        logic [1:0]  pl;
        n_flags = r_flags; n_fsize = r_fsize; n_fcode = r_fcode; n_chan = r_chan;
        n_rate = r_rate; n_avg = r_avg; n_align = r_align; n_bits = r_bits;
        n_clen = r_clen; n_fact = r_fact;
        if (w_pos < 64'd4) begin
            if (tagb(TAG_RIFF, w_lane) != i_byte) n_flags[0] = 1'b0;
        end else if (w_pos >= 64'd8 && w_pos < 64'd12) begin
            if (tagb(TAG_WAVE, w_lane) != i_byte) n_flags[1] = 1'b0;
        end else if (w_pos >= 64'd12 && w_pos < 64'd16) begin
            if (tagb(TAG_FMT, w_lane) != i_byte) n_flags[2] = 1'b0;
        end else if (w_pos >= 64'd16 && w_pos < 64'd20) begin
            n_fsize = put32(r_fsize, w_lane, i_byte);
        end else if (w_pos >= 64'd20 && w_pos < 64'd22) begin
            n_fcode = 16'(put32({16'd0, r_fcode}, {1'b0, w_lane[0]}, i_byte));
        end else if (w_pos >= 64'd22 && w_pos < 64'd24) begin
            n_chan = 16'(put32({16'd0, r_chan}, {1'b0, w_lane[0]}, i_byte));
        end else if (w_pos >= 64'd24 && w_pos < 64'd28) begin
            n_rate = put32(r_rate, w_lane, i_byte);
        end else if (w_pos >= 64'd28 && w_pos < 64'd32) begin
            n_avg = put32(r_avg, w_lane, i_byte);
        end else if (w_pos >= 64'd32 && w_pos < 64'd34) begin
            n_align = 16'(put32({16'd0, r_align}, {1'b0, w_lane[0]}, i_byte));
        end else if (w_pos >= 64'd34 && w_pos < 64'd36) begin
            n_bits = 16'(put32({16'd0, r_bits}, {1'b0, w_lane[0]}, i_byte));
        end
        p = {32'd0, n_fsize} + 64'd20;
        pl = 2'(w_pos - p);
        w_tag_data = tagb(TAG_DATA, pl);
        w_tag_fact = tagb(TAG_FACT, pl);
        if (w_pos >= 64'd20) begin
            if (w_pos >= p && w_pos < p + 64'd4) begin
                if (w_tag_data != i_byte) n_flags[3] = 1'b0;
                if (w_tag_fact != i_byte) n_flags[4] = 1'b0;
                if (w_pos == p + 64'd3 && !n_flags[3] && n_flags[4]) n_fact = 1'b1;
            end else if (w_pos >= p + 64'd4 && w_pos < p + 64'd8) begin
                if (!r_fact && r_flags[3]) n_clen = put32(r_clen, pl, i_byte);
            end else if (r_fact && w_pos >= p + 64'd12 && w_pos < p + 64'd16) begin
                if (w_pos == p + 64'd12) n_flags[3] = 1'b1;
                if (w_tag_data != i_byte) n_flags[3] = 1'b0;
            end else if (r_fact && w_pos >= p + 64'd16 && w_pos < p + 64'd20) begin
                if (r_flags[3]) n_clen = put32(r_clen, pl, i_byte);
            end
        end
    end

    // final evaluation
    logic        w_d1, w_d2;
    logic [63:0] w_ul;
    logic [32:0] w_fprod;
    logic [31:0] w_fsz;
    assign w_n = 64'(r_cnt);
    assign w_p = {32'd0, r_fsize} + 64'd20;
    assign w_d1 = !r_fact && r_flags[3] && w_n >= w_p + 64'd4;
    assign w_d2 = r_fact && r_flags[3] && w_n >= w_p + 64'd16;
    assign w_ul = (w_d1 || w_d2) ? {32'd0, r_clen} : 64'd0;
    assign w_fprod = 33'(({16'd0, r_chan} * {16'd0, r_bits}) >> 3);
    assign w_fsz = w_fprod[31:0];

    logic        div_done;
    logic [31:0] div_q;
    whc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(i_cmd.div_sel ? w_ul[31:0] : r_avg),
        .i_den(i_cmd.div_sel ? w_fsz : {16'd0, r_align}),
        .o_done(div_done), .o_quot(div_q)
    );

    logic [3:0]  w_st;
    always_comb begin
        w_st = ST_OK;
        if (w_n < 64'd44) w_st = ST_SHORT;
        else if (!r_flags[0]) w_st = ST_RIFF;
        else if (!r_flags[1]) w_st = ST_WAVE;
        else if (!r_flags[2]) w_st = ST_FMT;
        else if (w_n < w_ul + {32'd0, r_fsize} + 64'd28) w_st = ST_TRUNC;
        else if (r_fcode != 16'd1) w_st = ST_NOT_PCM;
        else if (r_align == 16'd0) w_st = ST_ZERO_DIV;
        else if (r_rate != r_q1) w_st = ST_RATE;
        else if (w_fsz == 32'd0) w_st = ST_ZERO_DIV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0; r_flags <= '1; r_fsize <= '0; r_fcode <= '0; r_chan <= '0;
            r_rate <= '0; r_avg <= '0; r_align <= '0; r_bits <= '0; r_clen <= '0;
            r_fact <= 1'b0; r_last <= 1'b0;
        end else if (i_cmd.take) begin
            if (r_cnt != CMAX) begin
                r_cnt <= r_cnt + 1'b1;
                r_flags <= n_flags; r_fsize <= n_fsize; r_fcode <= n_fcode;
                r_chan <= n_chan; r_rate <= n_rate; r_avg <= n_avg;
                r_align <= n_align; r_bits <= n_bits; r_clen <= n_clen;
                r_fact <= n_fact;
            end
            r_last <= i_last;
        end
        if (i_cmd.latch_q1) r_q1 <= div_q;
        if (i_cmd.fin_load) begin
            o_status <= w_st;
            o_channel_count <= r_chan;
            o_sample_rate <= r_rate;
            o_sample_bits <= r_bits;
            o_payload_bytes <= w_ul[31:0];
            o_frame_total <= (w_st == ST_OK) ? div_q : 32'd0;
            o_payload_offset <= 33'(w_d2 ? w_p + 64'd20 : w_p + 64'd8);
            o_file_length <= 32'(w_n);
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.last_seen = r_last;
endmodule

// ----- hdl/whc_controller.sv -----
// ----------------------------------------------------------------------------
// whc_controller
// Sequencer: byte intake, the two divisions, result hand-off.
// ----------------------------------------------------------------------------
module whc_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  whc_pkg::t_stat i_stat,
    output whc_pkg::t_cmd  o_cmd
);
    import whc_pkg::*;
    t_state r_state, n_state;
    logic   r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ov <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ov = r_ov;
        o_cmd = '0;
        o_in_ready = 1'b0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            S_RUN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                end else if (i_stat.last_seen) begin
                    n_state = S_DIV1_START;
                end
            end
            S_DIV1_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.latch_q1 = 1'b1;
                    n_state = S_DIV2_START;
                end
            end
            S_DIV2_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = 1'b1;
                n_state = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.div_sel = 1'b1;
                if (!r_ov || i_out_ready) begin
                    o_cmd.fin_load = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
        if (r_state == S_RUN && i_in_valid && i_stat.last_seen) begin
            o_in_ready = 1'b0;
            o_cmd.take = 1'b0;
            n_state = S_DIV1_START;
        end
    end

    assign o_out_valid = r_ov;
endmodule

// ----- sim/wav_header_checker_core_tb.sv -----
// ----------------------------------------------------------------------------
// wav_header_checker_core_tb
// Self-checking bench: streams whole WAV files byte by byte into the core,
// predicts each per-file result word and compares it field by field with
// the core's output, under varying source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module wav_header_checker_core_tb;
    import whc_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] payload_bytes;
        logic [31:0] frame_total;
        logic [32:0] payload_offset;
        logic [31:0] file_length;
    } hdr_report_t;

    typedef enum int {
        F_GOOD, F_FACT, F_BAD_RIFF, F_BAD_WAVE, F_BAD_FMT, F_TRUNC, F_NOT_PCM,
        F_RATE, F_ZERO_ALIGN, F_ZERO_FRAME, F_NO_DATA, F_CUT_TAG, F_SHORT,
        F_NOISE, F_HUGE
    } file_kind_t;

    typedef struct {
        file_kind_t kind;
        bit         typed;
        logic [3:0] status;
    } plan_row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_FILES     = 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    whc_stream_if #(.T(in_word_t))    in_ch ();
    whc_stream_if #(.T(hdr_report_t)) out_ch ();

    wav_header_checker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [63:0] pr_count;
    logic [4:0]  pr_flags;
    logic [31:0] pr_fmt_size;
    logic [15:0] pr_fmt_code;
    logic [15:0] pr_chan;
    logic [31:0] pr_rate;
    logic [31:0] pr_avg;
    logic [15:0] pr_align;
    logic [15:0] pr_bits;
    logic [31:0] pr_len;
    logic        pr_fact;

    hdr_report_t report_q[$];
    logic [7:0]  file_q[$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 0;
    int          idle_cycles = 0;

    localparam logic [4:0] FL_RIFF = 5'h01, FL_WAVE = 5'h02, FL_FMT = 5'h04,
                           FL_DATA = 5'h08, FL_FACT = 5'h10;

    function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [63:0] off);
        return tag[off[1:0]*8 +: 8];
    endfunction

    function automatic void clear_parser();
        pr_count = 0; pr_flags = 5'h1f; pr_fmt_size = 0; pr_fmt_code = 0;
        pr_chan = 0; pr_rate = 0; pr_avg = 0; pr_align = 0; pr_bits = 0;
        pr_len = 0; pr_fact = 0;
    endfunction

    function automatic void parse_byte(logic [63:0] pos, logic [7:0] b);
        logic [63:0] p;
        logic [63:0] o;
        if (pos < 4) begin
            if (tag_byte(TAG_RIFF, pos) != b) pr_flags &= ~FL_RIFF;
        end else if (pos >= 8 && pos < 12) begin
            if (tag_byte(TAG_WAVE, pos) != b) pr_flags &= ~FL_WAVE;
        end else if (pos >= 12 && pos < 16) begin
            if (tag_byte(TAG_FMT, pos) != b) pr_flags &= ~FL_FMT;
        end else if (pos >= 16 && pos < 20) pr_fmt_size[(pos-16)*8 +: 8] = b;
        else if (pos >= 20 && pos < 22) pr_fmt_code[(pos-20)*8 +: 8] = b;
        else if (pos >= 22 && pos < 24) pr_chan[(pos-22)*8 +: 8] = b;
        else if (pos >= 24 && pos < 28) pr_rate[(pos-24)*8 +: 8] = b;
        else if (pos >= 28 && pos < 32) pr_avg[(pos-28)*8 +: 8] = b;
        else if (pos >= 32 && pos < 34) pr_align[(pos-32)*8 +: 8] = b;
        else if (pos >= 34 && pos < 36) pr_bits[(pos-34)*8 +: 8] = b;
        if (pos < 20) return;
        p = {32'd0, pr_fmt_size} + 20;
        if (pos >= p && pos < p + 4) begin
            o = pos - p;
            if (tag_byte(TAG_DATA, o) != b) pr_flags &= ~FL_DATA;
            if (tag_byte(TAG_FACT, o) != b) pr_flags &= ~FL_FACT;
            if (pos == p + 3 && !pr_flags[3] && pr_flags[4]) pr_fact = 1;
        end else if (pos >= p + 4 && pos < p + 8) begin
            o = pos - p - 4;
            if (!pr_fact && pr_flags[3]) pr_len[o[1:0]*8 +: 8] = b;
        end else if (pr_fact && pos >= p + 12 && pos < p + 16) begin
            o = pos - p - 12;
            if (pos == p + 12) pr_flags |= FL_DATA;
            if (tag_byte(TAG_DATA, o) != b) pr_flags &= ~FL_DATA;
        end else if (pr_fact && pos >= p + 16 && pos < p + 20) begin
            o = pos - p - 16;
            if (pr_flags[3]) pr_len[o[1:0]*8 +: 8] = b;
        end
    endfunction

    function automatic bit predict_report(in_word_t w, output hdr_report_t r);
        logic [63:0] n, p, ul, fsz;
        bit d1, d2;
        if (pr_count < 64'hffff_ffff) begin
            parse_byte(pr_count, w.data_byte);
            pr_count++;
        end
        if (!w.last_byte) return 0;
        n = pr_count;
        p = {32'd0, pr_fmt_size} + 20;
        d1 = !pr_fact && pr_flags[3] && n >= p + 4;
        d2 = pr_fact && pr_flags[3] && n >= p + 16;
        ul = (d1 || d2) ? {32'd0, pr_len} : 64'd0;
        fsz = ({48'd0, pr_chan} * {48'd0, pr_bits}) / 8;
        r.frame_total = 0;
        if (n < 44) r.status = ST_SHORT;
        else if (!pr_flags[0]) r.status = ST_RIFF;
        else if (!pr_flags[1]) r.status = ST_WAVE;
        else if (!pr_flags[2]) r.status = ST_FMT;
        else if (n < ul + pr_fmt_size + 28) r.status = ST_TRUNC;
        else if (pr_fmt_code != 1) r.status = ST_NOT_PCM;
        else if (pr_align == 0) r.status = ST_ZERO_DIV;
        else if (pr_rate != pr_avg / pr_align) r.status = ST_RATE;
        else if (fsz == 0) r.status = ST_ZERO_DIV;
        else begin
            r.status = ST_OK;
            r.frame_total = 32'(ul / fsz);
        end
        r.channel_count = pr_chan;
        r.sample_rate = pr_rate;
        r.sample_bits = pr_bits;
        r.payload_bytes = ul[31:0];
        r.payload_offset = 33'(d2 ? p + 20 : p + 8);
        r.file_length = n[31:0];
        clear_parser();
        return 1;
    endfunction

    function automatic void push_word(logic [31:0] v, int nb);
        for (int i = 0; i < nb; i++) file_q.push_back(v[i*8 +: 8]);
    endfunction

    function automatic void build_file(file_kind_t kind);
        int fs, body, ch, bits, align, cut, idx;
        logic [31:0] rate, lfield;
        bit fact;
        file_q.delete();
        if (kind == F_NOISE) begin
            repeat ($urandom_range(1, 90)) file_q.push_back(8'($urandom));
            return;
        end
        fs = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : 16;
        ch = $urandom_range(1, 8);
        bits = 8 * $urandom_range(1, 4);
        align = ch * bits / 8;
        rate = $urandom_range(1, 200000);
        body = $urandom_range(0, 24);
        lfield = body;
        fact = (kind == F_FACT) || ($urandom_range(0, 4) == 0);
        if (kind == F_HUGE) begin
            ch = 16'hffff; bits = 16'hffff; align = 1; rate = 32'hffff_ffff;
            lfield = 32'hffff_ffff;
        end
        push_word(TAG_RIFF, 4); push_word($urandom, 4);
        push_word(TAG_WAVE, 4); push_word(TAG_FMT, 4); push_word(fs, 4);
        push_word(1, 2); push_word(ch, 2); push_word(rate, 4);
        push_word(rate * align, 4); push_word(align, 2); push_word(bits, 2);
        repeat (fs - 16) file_q.push_back(8'($urandom));
        if (fact) begin
            push_word(TAG_FACT, 4); push_word(4, 4); push_word($urandom, 4);
        end
        idx = file_q.size();
        push_word(TAG_DATA, 4); push_word(lfield, 4);
        repeat (body) file_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
        case (kind)
            F_BAD_RIFF: file_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            F_BAD_WAVE: file_q[$urandom_range(8, 11)] ^= 8'(1 << $urandom_range(0, 7));
            F_BAD_FMT: file_q[$urandom_range(12, 15)] ^= 8'(1 << $urandom_range(0, 7));
            F_NOT_PCM: file_q[20] = 8'($urandom_range(2, 255));
            F_RATE: file_q[24] ^= 8'h01;
            F_ZERO_ALIGN: begin file_q[32] = 0; file_q[33] = 0; end
            F_ZERO_FRAME: begin file_q[34] = 0; file_q[35] = 0; end
            F_NO_DATA: file_q[idx + $urandom_range(0, 3)] ^= 8'h20;
            F_TRUNC: begin
                file_q[idx + 4] = 8'($urandom_range(200, 255));
            end
            F_CUT_TAG: begin
                cut = idx + $urandom_range(1, 7);
                while (file_q.size() > cut) void'(file_q.pop_back());
            end
            F_SHORT: while (file_q.size() > 43) void'(file_q.pop_back());
            default: ;
        endcase
        if (kind == F_SHORT) begin
            cut = $urandom_range(1, 43);
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
    endfunction

    // valid stays high after the last word; the caller drops it
    task automatic send_file(bit typed, logic [3:0] typed_status);
        in_word_t w;
        hdr_report_t r;
        for (int i = 0; i < file_q.size(); i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            w.data_byte = file_q[i];
            w.last_byte = (i == file_q.size() - 1);
            in_ch.valid <= 1'b1;
            in_ch.data <= w;
            do @(posedge i_clk); while (!in_ch.ready);
            if (predict_report(w, r)) begin
                if (typed) r.status = typed_status;
                report_q.push_back(r);
            end
        end
    endtask

    task automatic drain();
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    file_kind_t random_kind;

    always @(posedge i_clk) begin
        hdr_report_t exp_r;
        if (out_ch.valid && out_ch.ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_ch.data);
                errors++;
            end else begin
                exp_r = report_q.pop_front();
                if (exp_r !== out_ch.data) begin
                    errors++;
                    $display("%0t: mismatch exp %h act %h", $time, exp_r, out_ch.data);
                    $display("  status %0d/%0d ch %0d/%0d rate %0d/%0d bits %0d/%0d",
                             exp_r.status, out_ch.data.status, exp_r.channel_count,
                             out_ch.data.channel_count, exp_r.sample_rate,
                             out_ch.data.sample_rate, exp_r.sample_bits,
                             out_ch.data.sample_bits);
                    $display("  bytes %0d/%0d frames %0d/%0d off %0d/%0d len %0d/%0d",
                             exp_r.payload_bytes, out_ch.data.payload_bytes,
                             exp_r.frame_total, out_ch.data.frame_total,
                             exp_r.payload_offset, out_ch.data.payload_offset,
                             exp_r.file_length, out_ch.data.file_length);
                end
            end
        end
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_req && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    plan_row_t plan[] = '{
        '{F_SHORT, 1, ST_SHORT}, '{F_GOOD, 0, ST_OK}, '{F_FACT, 0, ST_OK},
        '{F_BAD_RIFF, 1, ST_RIFF}, '{F_BAD_WAVE, 1, ST_WAVE},
        '{F_BAD_FMT, 1, ST_FMT}, '{F_TRUNC, 1, ST_TRUNC},
        '{F_NOT_PCM, 1, ST_NOT_PCM}, '{F_RATE, 1, ST_RATE},
        '{F_ZERO_ALIGN, 1, ST_ZERO_DIV}, '{F_ZERO_FRAME, 1, ST_ZERO_DIV},
        '{F_NO_DATA, 0, ST_OK}, '{F_CUT_TAG, 0, ST_OK}, '{F_HUGE, 1, ST_TRUNC},
        '{F_NOISE, 0, ST_OK}
    };

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        clear_parser();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[i]) begin
            build_file(plan[i].kind);
            send_file(plan[i].typed, plan[i].status);
        end
        in_ch.valid <= 1'b0;
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 30) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 30) : 0;
            for (int f = 0; f < RAND_FILES; f++) begin
                if ($urandom_range(0, 9) < 7)
                    random_kind = $urandom_range(0, 1) ? F_GOOD : F_FACT;
                else random_kind = file_kind_t'($urandom_range(F_BAD_RIFF, F_HUGE));
                build_file(random_kind);
                send_file(0, ST_OK);
            end
            in_ch.valid <= 1'b0;
            drain();
        end
        // long sink hold-off while short files keep coming
        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_req = 1;
                repeat (600) @(posedge i_clk);
                hold_req = 0;
            end
            begin
                repeat (6) begin
                    build_file(F_SHORT);
                    while (file_q.size() > 2) void'(file_q.pop_back());
                    send_file(0, ST_OK);
                end
                in_ch.valid <= 1'b0;
            end
        join
        drain();
        repeat (150) @(posedge i_clk);
        if (errors == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
